@@ hdl/bblru_pkg.sv @@
package bblru_pkg;

   localparam int FUNC_W   = 2;
   localparam int ID_W     = 16;
   localparam int SIZE_W   = 64;
   localparam int STATUS_W = 2;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RESIZE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TRIM   = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_FRONT    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_INSERT   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_BIG  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic            rot;
      logic            cmp_en;
      logic [ID_W-1:0] cmp_id;
   } cell_ctl_type;

endpackage

@@ hdl/bblru_req_if.sv @@
interface bblru_req_if;
   logic                          valid;
   logic                          ready;
   logic [bblru_pkg::FUNC_W-1:0]  func;
   logic [bblru_pkg::ID_W-1:0]    item_id;
   logic [bblru_pkg::SIZE_W-1:0]  mem_size;

   modport source (output valid, func, item_id, mem_size, input ready);
   modport sink (input valid, func, item_id, mem_size, output ready);
endinterface

@@ hdl/bblru_rsp_if.sv @@
interface bblru_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bblru_pkg::STATUS_W-1:0] status;
   logic                           evict_valid;
   logic [bblru_pkg::ID_W-1:0]     evicted_id;
   logic [bblru_pkg::SIZE_W-1:0]   evicted_size;
   logic                           last;

   modport source (output valid, status, evict_valid, evicted_id, evicted_size, last,
                   input ready);
   modport sink (input valid, status, evict_valid, evicted_id, evicted_size, last,
                 output ready);
endinterface

@@ hdl/bblru_cell.sv @@
module bblru_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  bblru_pkg::cell_ctl_type ctl,
   input  logic                    shift_dn,
   input  logic                    live,
   input  bblru_pkg::entry_type    prev_entry,
   input  bblru_pkg::entry_type    next_entry,
   output bblru_pkg::entry_type    entry,
   output logic                    match
);

   bblru_pkg::entry_type entry_ff, entry_in;
   logic                 match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.rot) begin
         entry_in = next_entry;
      end else if (shift_dn) begin
         entry_in = prev_entry;
      end
      match_in = match_ff;
      if (ctl.cmp_en) begin
         match_in = live && (entry_ff.id == ctl.cmp_id);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

@@ hdl/byte_budget_lru_tracker_core.sv @@
// state path, accept to result registered: touch hit select, apply, report; trim select,
// check, report; too big select, apply, report; overflowing insert select, apply, add, report;
// insert select, apply, add, check, report; resize hit select, apply, resize, check, report;
// a budget prune after check adds one full rotation of the cell ring plus output stalls
// one transaction at a time, next accepted the cycle after its last result is registered;
// reset clears entry count, byte total and output valid, and sets byte_limit to all ones;
// the cell contents are left as they are and only entries below the count are ever read
module byte_budget_lru_tracker_core #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   bblru_req_if.sink                    req_chan,
   bblru_rsp_if.source                  rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [bblru_pkg::SIZE_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int SZ    = bblru_pkg::SIZE_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SELECT,
      S_APPLY,
      S_RESIZE,
      S_ADD,
      S_CHECK,
      S_PRUNE,
      S_REPORT
   } state_type;

   // control registers
   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [SZ-1:0]                    used_ff, used_in;
   logic [SZ-1:0]                    limit_ff, limit_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic                             cut_ff, cut_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // transaction payload registers
   logic [bblru_pkg::FUNC_W-1:0]     func_ff, func_in;
   logic [bblru_pkg::ID_W-1:0]       id_ff, id_in;
   logic [SZ-1:0]                    mem_ff, mem_in;
   logic [bblru_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                             hit_ff, hit_in;
   logic [LIST_DEPTH-1:0]            before_ff, before_in;
   logic [SZ-1:0]                    old_size_ff, old_size_in;
   bblru_pkg::entry_type             pend_ff, pend_in;
   logic [IDX_W-1:0]                 step_ff, step_in;
   logic [IDX_W-1:0]                 cut_idx_ff, cut_idx_in;
   logic [SZ-1:0]                    acc_ff, acc_in;

   // output register
   logic [bblru_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                             rsp_evict_ff, rsp_evict_in;
   logic [bblru_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [SZ-1:0]                    rsp_size_ff, rsp_size_in;
   logic                             rsp_last_ff, rsp_last_in;

   // cell ring
   bblru_pkg::cell_ctl_type          cell_ctl;
   bblru_pkg::entry_type             head_entry;
   bblru_pkg::entry_type             cell_entry [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]            cell_match;
   logic [LIST_DEPTH-1:0]            shift_dn;
   logic [LIST_DEPTH-1:0]            live;

   // hit search
   logic [LIST_DEPTH-1:0]            match_incl;
   logic [LIST_DEPTH-1:0]            match_before;
   logic [LIST_DEPTH-1:0]            match_first;
   logic [SZ-1:0]                    sel_size;

   // arithmetic and handshake helpers
   logic [SZ:0]                      add_sum;
   logic [SZ:0]                      prune_sum;
   logic                             step_live;
   logic                             prune_over;
   logic                             evict_now;
   logic                             out_free;
   logic                             prune_stall;

   // list cells: cell 0 is the most recent entry; shift_dn moves entries toward the tail,
   // rot turns the whole ring one place toward the head (cell 0 wraps to the tail)
   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      bblru_pkg::entry_type prev_e;
      bblru_pkg::entry_type next_e;

      if (g == 0) begin : g_head
         assign prev_e = head_entry;
      end else begin : g_body
         assign prev_e = cell_entry[g-1];
      end

      if (g == LIST_DEPTH - 1) begin : g_tail
         assign next_e = cell_entry[0];
      end else begin : g_link
         assign next_e = cell_entry[g+1];
      end

      assign live[g] = (count_ff > CNT_W'(g));

      bblru_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .shift_dn   (shift_dn[g]),
         .live       (live[g]),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .entry      (cell_entry[g]),
         .match      (cell_match[g])
      );
   end

   // first match nearest the front: log-depth prefix or, then one-hot select of its size
   always_comb begin
      match_incl = cell_match;
      for (int s = 1; s < LIST_DEPTH; s = s * 2) begin
         match_incl = match_incl | (match_incl << s);
      end
      match_before = match_incl << 1;
      match_first  = cell_match & ~match_before;
      sel_size     = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         sel_size = sel_size | ({SZ{match_first[i]}} & cell_entry[i].size);
      end
   end

   // during a prune, cell 0 holds the entry at the current step
   assign step_live   = (CNT_W'(step_ff) < count_ff);
   assign prune_sum   = {1'b0, acc_ff} + {1'b0, cell_entry[0].size};
   assign prune_over  = prune_sum[SZ] || (prune_sum[SZ-1:0] > limit_ff);
   assign evict_now   = step_live && (cut_ff || prune_over);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   // a new eviction pushes the held one out, which needs the output register
   assign prune_stall = evict_now && pend_valid_ff && !out_free;
   assign add_sum     = {1'b0, used_ff} + {1'b0, mem_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      limit_in      = limit_ff;
      pend_valid_in = pend_valid_ff;
      cut_in        = cut_ff;
      rsp_valid_in  = rsp_valid_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      mem_in        = mem_ff;
      status_in     = status_ff;
      hit_in        = hit_ff;
      before_in     = before_ff;
      old_size_in   = old_size_ff;
      pend_in       = pend_ff;
      step_in       = step_ff;
      cut_idx_in    = cut_idx_ff;
      acc_in        = acc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_last_in   = rsp_last_ff;

      cell_ctl.rot    = 1'b0;
      cell_ctl.cmp_en = 1'b0;
      cell_ctl.cmp_id = req_chan.item_id;
      shift_dn        = '0;
      // front load: a hit keeps its old size unless resized, an insert takes the new size
      head_entry.id   = id_ff;
      head_entry.size = (hit_ff && (func_ff != bblru_pkg::FUNC_RESIZE)) ? old_size_ff : mem_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               func_in         = req_chan.func;
               id_in           = req_chan.item_id;
               mem_in          = req_chan.mem_size;
               status_in       = bblru_pkg::STAT_FRONT;
               pend_valid_in   = 1'b0;
               cell_ctl.cmp_en = 1'b1;
               state_in        = S_SELECT;
            end
         end

         S_SELECT: begin
            hit_in      = |cell_match;
            before_in   = match_before;
            old_size_in = sel_size;
            case (func_ff)
               bblru_pkg::FUNC_TOUCH,
               bblru_pkg::FUNC_RESIZE: state_in = S_APPLY;
               bblru_pkg::FUNC_TRIM:   state_in = S_CHECK;
               default:                state_in = S_REPORT;
            endcase
         end

         S_APPLY: begin
            if (hit_ff) begin
               // cells up to and including the hit shift down, the hit lands in cell 0
               shift_dn = ~before_ff;
               if (func_ff == bblru_pkg::FUNC_RESIZE) begin
                  used_in  = used_ff - old_size_ff;
                  state_in = S_RESIZE;
               end else begin
                  state_in = S_REPORT;
               end
            end else if (mem_ff > limit_ff) begin
               status_in = bblru_pkg::STAT_TOO_BIG;
               state_in  = S_REPORT;
            end else begin
               shift_dn = '1;
               if (count_ff == FULL_CNT) begin
                  // full list: the tail falls out and is held as the first eviction
                  pend_valid_in = 1'b1;
                  pend_in       = cell_entry[LIST_DEPTH-1];
                  used_in       = used_ff - cell_entry[LIST_DEPTH-1].size;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_ADD;
            end
         end

         S_RESIZE: begin
            used_in  = used_ff + mem_ff;
            state_in = S_CHECK;
         end

         S_ADD: begin
            if (add_sum[SZ]) begin
               // total wraps: keep the item, leave the total, skip the budget check
               status_in = bblru_pkg::STAT_OVERFLOW;
               state_in  = S_REPORT;
            end else begin
               status_in = bblru_pkg::STAT_INSERT;
               used_in   = add_sum[SZ-1:0];
               state_in  = S_CHECK;
            end
         end

         S_CHECK: begin
            if (used_ff > limit_ff) begin
               step_in  = '0;
               acc_in   = '0;
               cut_in   = 1'b0;
               state_in = S_PRUNE;
            end else begin
               state_in = S_REPORT;
            end
         end

         S_PRUNE: begin
            if (!prune_stall) begin
               cell_ctl.rot = 1'b1;
               step_in      = step_ff + IDX_W'(1);
               if (step_live && !cut_ff) begin
                  if (prune_over) begin
                     cut_in     = 1'b1;
                     cut_idx_in = step_ff;
                     used_in    = acc_ff;
                  end else begin
                     acc_in = prune_sum[SZ-1:0];
                  end
               end
               if (evict_now) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = status_ff;
                     rsp_evict_in  = 1'b1;
                     rsp_id_in     = pend_ff.id;
                     rsp_size_in   = pend_ff.size;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = cell_entry[0];
               end
               // after a full turn the ring is back in order
               if (step_ff == LAST_IDX) begin
                  if (cut_in) begin
                     count_in = CNT_W'(cut_idx_in);
                  end else begin
                     used_in = acc_in;
                  end
                  state_in = S_REPORT;
               end
            end
         end

         S_REPORT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_evict_in  = pend_valid_ff;
               rsp_id_in     = pend_valid_ff ? pend_ff.id : '0;
               rsp_size_in   = pend_valid_ff ? pend_ff.size : '0;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         used_ff       <= '0;
         limit_ff      <= '1;
         pend_valid_ff <= 1'b0;
         cut_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         limit_ff      <= limit_in;
         pend_valid_ff <= pend_valid_in;
         cut_ff        <= cut_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      id_ff         <= id_in;
      mem_ff        <= mem_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      before_ff     <= before_in;
      old_size_ff   <= old_size_in;
      pend_ff       <= pend_in;
      step_ff       <= step_in;
      cut_idx_ff    <= cut_idx_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // port drive
   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.evict_valid  = rsp_evict_ff;
   assign rsp_chan.evicted_id   = rsp_id_ff;
   assign rsp_chan.evicted_size = rsp_size_ff;
   assign rsp_chan.last         = rsp_last_ff;

   // entry count never passes the list depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above list depth");

   // no eviction may be held over into a new transaction
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_SELECT) |-> !pend_valid_ff)
      else $error("held eviction leaked across transactions");

   // a cut point always lies inside the listed entries
   a_cut_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PRUNE && cut_ff) |-> (CNT_W'(cut_idx_ff) < count_ff))
      else $error("prune cut beyond entry count");

endmodule
